[src/acfd_pkg.sv]
package acfd_pkg;

  // Default length of the '+' start run
  localparam int unsigned START_RUN_DEF = 3;

  // Characters of the frame syntax
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_BRIGHT  = 8'h21;
  localparam logic [7:0] CHAR_COLOR   = 8'h23;
  localparam logic [7:0] CHAR_RSVD    = 8'h25;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;

  // Number of payload characters in a frame
  localparam int unsigned PAYLOAD_LEN = 6;

  // Brightness scaling: pct = floor((value + 1) * 100 / 999999).
  // The divide is a multiply by ceil(2^47 / 999999) and a shift by 47,
  // exact for every dividend up to (999999 + 1) * 100.
  localparam int unsigned     DEC_W        = 20;
  localparam int unsigned     SCALED_W     = 27;
  localparam int unsigned     RECIP_W      = 28;
  localparam int unsigned     RECIP_SHIFT  = 47;
  localparam logic [RECIP_W-1:0] RECIP_FULL_SCALE = 28'd140737630;

  // Kind of a completed frame
  typedef enum logic [1:0] {
    KIND_BRIGHT = 2'd0,
    KIND_COLOR  = 2'd1,
    KIND_RSVD   = 2'd2
  } kind_t;

  // One result transaction
  typedef struct packed {
    logic        frame_done;
    logic [1:0]  cmd_kind;
    logic        digit_error;
    logic [6:0]  brightness_pct;
    logic [23:0] color;
  } result_t;

endpackage

[src/ascii_command_frame_decoder.sv]
// ascii_command_frame_decoder
//
// Input channel: one received byte per transaction on in_rx_char, with
// in_valid / in_ready. Output channel: one result per input byte, with
// out_valid / out_ready: the frame-done flag, the kind and digit error of
// the completed frame (both zero when no frame completed) and the held
// brightness and red, green, blue levels.
//
// Results are registered. Throughput is one byte per cycle while results are
// taken; the payload digits are folded into decimal and hex accumulators as
// they arrive, so the closing newline costs only one 27 x 28 constant
// multiply for the brightness scaling, which sets the critical path.
//
// A two-entry output buffer (result register plus skid register) holds
// results while the receiver stalls; one more byte is taken after the
// receiver stops, then in_ready drops until a result is taken.
//
// Reset (synchronous, rst_n low) empties the buffer, drops any partial
// frame and clears the held brightness and color to zero.
module ascii_command_frame_decoder #(
  parameter int unsigned START_RUN = acfd_pkg::START_RUN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_done,
  output logic [1:0]  out_cmd_kind,
  output logic        out_digit_error,
  output logic [6:0]  out_brightness_pct,
  output logic [7:0]  out_red_level,
  output logic [7:0]  out_green_level,
  output logic [7:0]  out_blue_level
);

  import acfd_pkg::*;

  localparam int unsigned PosW = $clog2(START_RUN + 9);
  localparam logic [PosW-1:0] RunEnd   = PosW'(START_RUN);
  localparam logic [PosW-1:0] CmdPos   = PosW'(START_RUN + 1);
  localparam logic [PosW-1:0] FirstPos = PosW'(START_RUN + 2);
  localparam logic [PosW-1:0] LastPos  = PosW'(START_RUN + 1 + PAYLOAD_LEN);
  localparam logic [PosW-1:0] EndPos   = PosW'(START_RUN + 2 + PAYLOAD_LEN);

  // Frame tracking state
  logic [PosW-1:0]  pos_r, pos_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic             done_r, done_nxt;
  kind_t            kind_r, kind_nxt;
  logic [DEC_W-1:0] dec_acc_r, dec_acc_nxt;
  logic [23:0]      hex_acc_r, hex_acc_nxt;
  logic             dec_bad_r, dec_bad_nxt;
  logic             hex_bad_r, hex_bad_nxt;
  logic [6:0]       bright_r, bright_nxt;
  logic [23:0]      color_r, color_nxt;

  // Output buffer
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;

  logic    push, pop;
  result_t res_new;

  // Character classification
  logic       is_dec, is_upper_hex, is_lower_hex, is_hex, is_cmd;
  logic [3:0] hex_val;
  kind_t      cmd_code;

  // Brightness scaling
  logic [DEC_W:0]                 dec_inc;
  logic [SCALED_W-1:0]            scaled;
  logic [SCALED_W+RECIP_W-1:0]    scaled_prod;
  logic [6:0]                     pct;

  assign push     = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;
  assign in_ready = !skid_valid_r;

  // Classify the incoming byte
  always_comb begin
    is_dec       = (in_rx_char >= CHAR_ZERO) && (in_rx_char <= CHAR_NINE);
    is_upper_hex = (in_rx_char >= CHAR_UPPER_A) && (in_rx_char <= CHAR_UPPER_F);
    is_lower_hex = (in_rx_char >= CHAR_LOWER_A) && (in_rx_char <= CHAR_LOWER_F);
    is_hex       = is_dec || is_upper_hex || is_lower_hex;
    hex_val      = is_dec ? in_rx_char[3:0] : (in_rx_char[3:0] + 4'd9);
    is_cmd       = (in_rx_char == CHAR_BRIGHT) || (in_rx_char == CHAR_COLOR) ||
                   (in_rx_char == CHAR_RSVD);
    case (in_rx_char)
      CHAR_BRIGHT: cmd_code = KIND_BRIGHT;
      CHAR_COLOR:  cmd_code = KIND_COLOR;
      default:     cmd_code = KIND_RSVD;
    endcase
  end

  // (value + 1) * 100 by shift and add, then divide by 999999 via reciprocal
  always_comb begin
    dec_inc     = {1'b0, dec_acc_r} + {{DEC_W{1'b0}}, 1'b1};
    scaled      = {dec_inc, 6'b0} + {1'b0, dec_inc, 5'b0} + {4'b0, dec_inc, 2'b0};
    scaled_prod = {{RECIP_W{1'b0}}, scaled} * {{SCALED_W{1'b0}}, RECIP_FULL_SCALE};
    pct         = scaled_prod[RECIP_SHIFT+6:RECIP_SHIFT];
  end

  // Frame state machine and result for the current byte
  always_comb begin
    pos_nxt      = pos_r;
    in_frame_nxt = in_frame_r;
    done_nxt     = 1'b0;
    kind_nxt     = kind_r;
    dec_acc_nxt  = dec_acc_r;
    hex_acc_nxt  = hex_acc_r;
    dec_bad_nxt  = dec_bad_r;
    hex_bad_nxt  = hex_bad_r;
    bright_nxt   = bright_r;
    color_nxt    = color_r;

    // A completed frame is cleared by the following byte
    if (done_r) begin
      pos_nxt      = '0;
      in_frame_nxt = 1'b0;
    end

    if (in_frame_nxt) begin
      pos_nxt = pos_nxt + 1'b1;
      if (pos_nxt == CmdPos) begin
        if (is_cmd) begin
          kind_nxt = cmd_code;
        end else begin
          in_frame_nxt = 1'b0;
          pos_nxt      = '0;
        end
      end else if ((pos_nxt >= FirstPos) && (pos_nxt <= LastPos)) begin
        // Fold each payload digit into both accumulators
        if (pos_nxt == FirstPos) begin
          dec_acc_nxt = DEC_W'(in_rx_char[3:0]);
          hex_acc_nxt = {20'b0, hex_val};
          dec_bad_nxt = !is_dec;
          hex_bad_nxt = !is_hex;
        end else begin
          dec_acc_nxt = {dec_acc_r[DEC_W-4:0], 3'b0} + {dec_acc_r[DEC_W-2:0], 1'b0} +
                        DEC_W'(in_rx_char[3:0]);
          hex_acc_nxt = {hex_acc_r[19:0], hex_val};
          dec_bad_nxt = dec_bad_r || !is_dec;
          hex_bad_nxt = hex_bad_r || !is_hex;
        end
      end else if (pos_nxt == EndPos) begin
        if (in_rx_char == CHAR_NEWLINE) begin
          done_nxt = 1'b1;
        end else begin
          in_frame_nxt = 1'b0;
        end
        pos_nxt = '0;
      end else begin
        in_frame_nxt = 1'b0;
      end
    end

    // Outside a frame: count the start run
    if (!in_frame_nxt) begin
      if (in_rx_char == CHAR_PLUS) begin
        pos_nxt = pos_nxt + 1'b1;
        if (pos_nxt == RunEnd) begin
          in_frame_nxt = 1'b1;
        end
      end else begin
        pos_nxt = '0;
      end
    end

    res_new             = '0;
    res_new.frame_done  = done_nxt;
    if (done_nxt) begin
      res_new.cmd_kind = kind_r;
      case (kind_r)
        KIND_BRIGHT: begin
          res_new.digit_error = dec_bad_r;
          if (!dec_bad_r) begin
            bright_nxt = pct;
          end
        end
        KIND_COLOR: begin
          res_new.digit_error = hex_bad_r;
          if (!hex_bad_r) begin
            color_nxt = hex_acc_r;
          end
        end
        default: res_new.digit_error = 1'b0;
      endcase
    end
    res_new.brightness_pct = bright_nxt;
    res_new.color          = color_nxt;
  end

  // Two-entry output buffer
  always_comb begin
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = res_new;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = res_new;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and held settings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      in_frame_r   <= 1'b0;
      done_r       <= 1'b0;
      bright_r     <= '0;
      color_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (push) begin
        pos_r      <= pos_nxt;
        in_frame_r <= in_frame_nxt;
        done_r     <= done_nxt;
        bright_r   <= bright_nxt;
        color_r    <= color_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
    if (push) begin
      kind_r    <= kind_nxt;
      dec_acc_r <= dec_acc_nxt;
      hex_acc_r <= hex_acc_nxt;
      dec_bad_r <= dec_bad_nxt;
      hex_bad_r <= hex_bad_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_done     = out_data_r.frame_done;
  assign out_cmd_kind       = out_data_r.cmd_kind;
  assign out_digit_error    = out_data_r.digit_error;
  assign out_brightness_pct = out_data_r.brightness_pct;
  assign out_red_level      = out_data_r.color[23:16];
  assign out_green_level    = out_data_r.color[15:8];
  assign out_blue_level     = out_data_r.color[7:0];

endmodule
